### rtl/sl3hj_pkg.sv
`default_nettype none
package sl3hj_pkg;

   typedef struct packed {
      logic signed [31:0] tmpl_x;
      logic signed [31:0] tmpl_y;
      logic signed [31:0] warped_x;
      logic signed [31:0] warped_y;
      logic signed [31:0] hom_depth;
      logic signed [31:0] grad_x;
      logic signed [31:0] grad_y;
      logic               last_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] jac_0;
      logic signed [31:0] jac_1;
      logic signed [31:0] jac_2;
      logic signed [31:0] jac_3;
      logic signed [31:0] jac_4;
      logic signed [31:0] jac_5;
      logic signed [31:0] jac_6;
      logic signed [31:0] jac_7;
      logic               last_out;
      logic               depth_error;
   } rsp_type;

   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USE_WARP = 3'd0,
      CSR_WARP_00  = 3'd1,
      CSR_WARP_01  = 3'd2,
      CSR_WARP_10  = 3'd3,
      CSR_WARP_11  = 3'd4,
      CSR_WARP_20  = 3'd5,
      CSR_WARP_21  = 3'd6
   } csr_idx_type;

   localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

   // saturate a 34-bit signed value to 32 bits
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) r = SAT_MAX;
      else if (v < -34'sd2147483648) r = SAT_MIN;
      else r = v[31:0];
      return r;
   endfunction

   // saturate a 64-bit signed value to 32 bits
   function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) r = SAT_MAX;
      else if (v < -64'sd2147483648) r = SAT_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

### rtl/sl3_homography_pixel_jacobian.sv
`default_nettype none
// Channel   Ports                               Handshake
// request   req_start, req_busy, req_data       start & !busy
// result    rsp_strobe, rsp_data                one cycle, no back pressure
// config    csr_valid, csr_ready, csr_index,    valid & ready
//           csr_data
//
// A sample enters every cycle; busy stays low. A sample passes the warp
// products and sums in stages A to D, the bit-per-stage depth divider after
// its operand stage, then jacobian stages E to G, and the output register.
// Init mode samples flow through the same stages so order is kept.
// Reset clears valid bits and mode, loads the identity warp; no stall exists.
module sl3_homography_pixel_jacobian #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_start,
   output logic                     req_busy,
   input  wire sl3hj_pkg::req_type  req_data,
   output logic                     rsp_strobe,
   output sl3hj_pkg::rsp_type       rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [31:0]         csr_data
);
   import sl3hj_pkg::*;

   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   // configuration
   logic               use_warp_ff;
   logic signed [31:0] w00_ff, w01_ff, w10_ff, w11_ff, w20_ff, w21_ff;

   assign csr_ready = 1'b1;
   assign req_busy  = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_warp_ff <= 1'b0;
         w00_ff <= ONE; w01_ff <= '0; w10_ff <= '0;
         w11_ff <= ONE; w20_ff <= '0; w21_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_USE_WARP: use_warp_ff <= csr_data[0];
            CSR_WARP_00:  w00_ff <= csr_data;
            CSR_WARP_01:  w01_ff <= csr_data;
            CSR_WARP_10:  w10_ff <= csr_data;
            CSR_WARP_11:  w11_ff <= csr_data;
            CSR_WARP_20:  w20_ff <= csr_data;
            CSR_WARP_21:  w21_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // truncating Q multiply of two operands, saturated
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return sat64(p >>> FRAC_BITS);
   endfunction

   // stage A: warp column products with the warped point
   logic               a_v_ff, a_warp_ff, a_zero_ff, a_last_ff;
   logic signed [31:0] a_x_ff, a_y_ff, a_d_ff, a_gx_ff, a_gy_ff;
   logic signed [31:0] a_pxx_ff, a_pxy_ff, a_pyx_ff, a_pyy_ff;
   // stage B: derivative entries
   logic               b_v_ff, b_warp_ff, b_zero_ff, b_last_ff;
   logic signed [31:0] b_x_ff, b_y_ff, b_d_ff, b_gx_ff, b_gy_ff;
   logic signed [31:0] b_dxx_ff, b_dxy_ff, b_dyx_ff, b_dyy_ff;
   // stage C: gradient products
   logic               c_v_ff, c_warp_ff, c_zero_ff, c_last_ff;
   logic signed [31:0] c_x_ff, c_y_ff, c_d_ff, c_gx_ff, c_gy_ff;
   logic signed [31:0] c_p0_ff, c_p1_ff, c_p2_ff, c_p3_ff;
   // stage D: sums ahead of the divider
   logic               d_v_ff, d_warp_ff, d_zero_ff, d_last_ff;
   logic signed [31:0] d_x_ff, d_y_ff, d_d_ff, d_gx_ff, d_gy_ff, d_sx_ff, d_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0; b_v_ff <= 1'b0; c_v_ff <= 1'b0; d_v_ff <= 1'b0;
      end else begin
         a_v_ff <= req_start; b_v_ff <= a_v_ff; c_v_ff <= b_v_ff; d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_warp_ff <= use_warp_ff;
      a_zero_ff <= req_data.hom_depth == 32'sd0;
      a_last_ff <= req_data.last_in;
      a_x_ff  <= req_data.tmpl_x;   a_y_ff  <= req_data.tmpl_y;
      a_d_ff  <= req_data.hom_depth;
      a_gx_ff <= req_data.grad_x;   a_gy_ff <= req_data.grad_y;
      a_pxx_ff <= qmul(w20_ff, req_data.warped_x);
      a_pxy_ff <= qmul(w21_ff, req_data.warped_x);
      a_pyx_ff <= qmul(w20_ff, req_data.warped_y);
      a_pyy_ff <= qmul(w21_ff, req_data.warped_y);

      b_warp_ff <= a_warp_ff; b_zero_ff <= a_zero_ff; b_last_ff <= a_last_ff;
      b_x_ff <= a_x_ff; b_y_ff <= a_y_ff; b_d_ff <= a_d_ff;
      b_gx_ff <= a_gx_ff; b_gy_ff <= a_gy_ff;
      b_dxx_ff <= sat34(34'(w00_ff) - 34'(a_pxx_ff));
      b_dxy_ff <= sat34(34'(w01_ff) - 34'(a_pxy_ff));
      b_dyx_ff <= sat34(34'(w10_ff) - 34'(a_pyx_ff));
      b_dyy_ff <= sat34(34'(w11_ff) - 34'(a_pyy_ff));

      c_warp_ff <= b_warp_ff; c_zero_ff <= b_zero_ff; c_last_ff <= b_last_ff;
      c_x_ff <= b_x_ff; c_y_ff <= b_y_ff; c_d_ff <= b_d_ff;
      c_gx_ff <= b_gx_ff; c_gy_ff <= b_gy_ff;
      c_p0_ff <= qmul(b_dxx_ff, b_gx_ff);
      c_p1_ff <= qmul(b_dyx_ff, b_gy_ff);
      c_p2_ff <= qmul(b_dxy_ff, b_gx_ff);
      c_p3_ff <= qmul(b_dyy_ff, b_gy_ff);

      d_warp_ff <= c_warp_ff; d_zero_ff <= c_zero_ff; d_last_ff <= c_last_ff;
      d_x_ff <= c_x_ff; d_y_ff <= c_y_ff; d_d_ff <= c_zero_ff ? 32'sd1 : c_d_ff;
      d_gx_ff <= c_gx_ff; d_gy_ff <= c_gy_ff;
      d_sx_ff <= sat34(34'(c_p0_ff) + 34'(c_p1_ff));
      d_sy_ff <= sat34(34'(c_p2_ff) + 34'(c_p3_ff));
   end

   // two dividers side by side; the side band carries what the tail needs
   localparam int SIDE_W = 3 + 4 * 32;
   logic [SIDE_W-1:0] side_in, side_x, side_y;
   logic              q_v, q_v_unused;
   logic signed [31:0] q_x, q_y;

   assign side_in = {d_warp_ff, d_zero_ff, d_last_ff, d_x_ff, d_y_ff, d_gx_ff, d_gy_ff};

   sl3hj_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div_x (
      .clock, .reset, .in_valid(d_v_ff), .in_num(d_sx_ff), .in_den(d_d_ff),
      .in_side(side_in), .out_valid(q_v), .out_quo(q_x), .out_side(side_x));

   sl3hj_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div_y (
      .clock, .reset, .in_valid(d_v_ff), .in_num(d_sy_ff), .in_den(d_d_ff),
      .in_side(side_in), .out_valid(q_v_unused), .out_quo(q_y), .out_side(side_y));

   // stage E: pick gradient per mode
   logic               e_v_ff, e_err_ff, e_last_ff;
   logic signed [31:0] e_x_ff, e_y_ff, e_ix_ff, e_iy_ff;
   logic               s_warp, s_zero, s_last;
   logic signed [31:0] s_x, s_y, s_gx, s_gy;

   always_comb begin
      {s_warp, s_zero, s_last, s_x, s_y, s_gx, s_gy} = side_x;
   end

   // stage F: first products; stage G: second products for the output sums
   logic               f_v_ff, f_err_ff, f_last_ff;
   logic signed [31:0] f_x_ff, f_y_ff, f_ix_ff, f_iy_ff;
   logic signed [31:0] f_ixx_ff, f_iyy_ff, f_ixy_ff, f_iyx_ff;
   logic               g_v_ff, g_err_ff, g_last_ff;
   logic signed [31:0] g_ix_ff, g_iy_ff, g_ixx_ff, g_iyy_ff, g_ixy_ff, g_iyx_ff;
   logic signed [31:0] g_m0_ff, g_m1_ff, g_m2_ff, g_m3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0; f_v_ff <= 1'b0; g_v_ff <= 1'b0; rsp_strobe <= 1'b0;
      end else begin
         e_v_ff <= q_v; f_v_ff <= e_v_ff; g_v_ff <= f_v_ff; rsp_strobe <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      e_err_ff  <= s_warp & s_zero;
      e_last_ff <= s_last;
      e_x_ff <= s_x; e_y_ff <= s_y;
      e_ix_ff <= !s_warp ? s_gx : (s_zero ? 32'sd0 : q_x);
      e_iy_ff <= !s_warp ? s_gy : (s_zero ? 32'sd0 : q_y);

      f_err_ff <= e_err_ff; f_last_ff <= e_last_ff;
      f_x_ff <= e_x_ff; f_y_ff <= e_y_ff; f_ix_ff <= e_ix_ff; f_iy_ff <= e_iy_ff;
      f_ixx_ff <= qmul(e_ix_ff, e_x_ff);
      f_iyy_ff <= qmul(e_iy_ff, e_y_ff);
      f_ixy_ff <= qmul(e_ix_ff, e_y_ff);
      f_iyx_ff <= qmul(e_iy_ff, e_x_ff);

      g_err_ff <= f_err_ff; g_last_ff <= f_last_ff;
      g_ix_ff <= f_ix_ff; g_iy_ff <= f_iy_ff;
      g_ixx_ff <= f_ixx_ff; g_iyy_ff <= f_iyy_ff;
      g_ixy_ff <= f_ixy_ff; g_iyx_ff <= f_iyx_ff;
      g_m0_ff <= qmul(f_ixx_ff, f_x_ff);
      g_m1_ff <= qmul(f_iyy_ff, f_x_ff);
      g_m2_ff <= qmul(f_ixx_ff, f_y_ff);
      g_m3_ff <= qmul(f_iyy_ff, f_y_ff);

      // output register; warped zero depth forced Ix, Iy and so all terms to zero
      rsp_data.jac_0 <= sat34(34'(g_ixx_ff) - 34'(g_iyy_ff));
      rsp_data.jac_1 <= g_ixy_ff;
      rsp_data.jac_2 <= g_ix_ff;
      rsp_data.jac_3 <= g_iyx_ff;
      rsp_data.jac_4 <= sat34(34'(g_ixx_ff) + (34'(g_iyy_ff) <<< 1));
      rsp_data.jac_5 <= g_iy_ff;
      rsp_data.jac_6 <= sat34(-34'(g_m0_ff) - 34'(g_m1_ff));
      rsp_data.jac_7 <= sat34(-34'(g_m2_ff) - 34'(g_m3_ff));
      rsp_data.last_out    <= g_last_ff;
      rsp_data.depth_error <= g_err_ff;
   end

   logic unused_ok;
   assign unused_ok = q_v_unused ^ (^side_y);
endmodule
`default_nettype wire

### rtl/sl3hj_div.sv
`default_nettype none
// Pipelined signed divide: quo = sat32(trunc(num * 2^FRAC_BITS / den)), one quotient bit
// per stage, restoring on magnitudes. Side band rides along.
module sl3hj_div #(
   parameter int FRAC_BITS = 16,
   parameter int SIDE_W = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic signed [31:0] in_num,
   input  wire logic signed [31:0] in_den,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic signed [31:0]      out_quo,
   output logic [SIDE_W-1:0]       out_side
);
   import sl3hj_pkg::*;

   localparam int NW = 32 + FRAC_BITS;   // magnitude of shifted numerator
   localparam int NS = NW;               // one stage per quotient bit

   logic [NW-1:0]     rem_ff [NS+1];
   logic [NW-1:0]     quo_ff [NS+1];
   logic [31:0]       den_ff [NS+1];
   logic              neg_ff [NS+1];
   logic [SIDE_W-1:0] side_ff[NS+1];
   logic              vld_ff [NS+1];

   logic [31:0]       num_mag;
   logic [NW-1:0]     num_in;
   logic [31:0]       den_in;

   always_comb begin
      num_mag = in_num[31] ? 32'(-in_num) : in_num;
      num_in  = NW'(num_mag) << FRAC_BITS;
      den_in  = in_den[31] ? 32'(-{1'b0, in_den}) : in_den;
   end

   // stage 0 registers the operands; stage k+1 retires quotient bit NW-1-k
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NS; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 0; k < NS; k++) vld_ff[k+1] <= vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= num_in;
      quo_ff[0]  <= '0;
      den_ff[0]  <= den_in;
      neg_ff[0]  <= in_num[31] ^ in_den[31];
      side_ff[0] <= in_side;
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam int B = NW - 1 - k;
      logic [NW+31:0] trial;
      logic           fits;
      always_comb begin
         trial = {32'd0, den_ff[k]} << B;
         fits  = {32'd0, rem_ff[k]} >= trial;
      end
      always_ff @(posedge clock) begin
         rem_ff[k+1]  <= fits ? NW'({32'd0, rem_ff[k]} - trial) : rem_ff[k];
         quo_ff[k+1]  <= quo_ff[k] | (NW'(fits) << B);
         den_ff[k+1]  <= den_ff[k];
         neg_ff[k+1]  <= neg_ff[k];
         side_ff[k+1] <= side_ff[k];
      end
   end

   logic signed [NW+1:0] q_s;
   always_comb begin
      q_s = neg_ff[NS] ? -$signed({2'b00, quo_ff[NS]}) : $signed({2'b00, quo_ff[NS]});
      out_valid = vld_ff[NS];
      out_quo   = sat64(64'(q_s));
      out_side  = side_ff[NS];
   end
endmodule
`default_nettype wire

### test/sl3_homography_pixel_jacobian_tb.sv
`timescale 1ns / 100ps
module sl3_homography_pixel_jacobian_tb;
   import sl3hj_pkg::*;

   localparam int FRAC = 16;
   // warp stages, one divider stage per quotient bit, jacobian stages, output
   localparam int PIPE_DEPTH = 4 + 32 + FRAC + 1 + 3 + 1;
   localparam int CYCLE_LIMIT = 400000;

   typedef logic signed [63:0] wide_t;

   // Exact product, floor shift, then clamp to 32 bits.
   function automatic wide_t qmul(wide_t a, wide_t b);
      wide_t p;
      p = (a * b) >>> FRAC;
      return clamp32(p);
   endfunction

   function automatic wide_t clamp32(wide_t v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Quotient rounds toward zero, as SystemVerilog signed division does.
   function automatic wide_t qdiv(wide_t s, wide_t d);
      wide_t num;
      num = s * (64'sd1 <<< FRAC);
      return clamp32(num / d);
   endfunction

   class jacobian_scoreboard;
      rsp_type pending[$];
      logic warp_on;
      wide_t w00, w01, w10, w11, w20, w21;
      int mismatches;
      int checked;

      function void set_reg(csr_idx_type idx, logic [31:0] v);
         case (idx)
            CSR_USE_WARP: warp_on = v[0];
            CSR_WARP_00:  w00 = wide_t'($signed(v));
            CSR_WARP_01:  w01 = wide_t'($signed(v));
            CSR_WARP_10:  w10 = wide_t'($signed(v));
            CSR_WARP_11:  w11 = wide_t'($signed(v));
            CSR_WARP_20:  w20 = wide_t'($signed(v));
            CSR_WARP_21:  w21 = wide_t'($signed(v));
            default: ;
         endcase
      endfunction

      function void note_sample(req_type r);
         rsp_type e;
         wide_t x, y, wx, wy, d, gx, gy, ix, iy, ixx, iyy, ixy, iyx;
         wide_t dxx, dxy, dyx, dyy, sx, sy;
         x = wide_t'(r.tmpl_x); y = wide_t'(r.tmpl_y);
         wx = wide_t'(r.warped_x); wy = wide_t'(r.warped_y);
         d = wide_t'(r.hom_depth); gx = wide_t'(r.grad_x); gy = wide_t'(r.grad_y);
         e = '0;
         e.last_out = r.last_in;
         if (warp_on && d == 0) begin
            e.depth_error = 1'b1;
         end else begin
            if (warp_on) begin
               dxx = clamp32(w00 - qmul(w20, wx));
               dxy = clamp32(w01 - qmul(w21, wx));
               dyx = clamp32(w10 - qmul(w20, wy));
               dyy = clamp32(w11 - qmul(w21, wy));
               sx = clamp32(qmul(dxx, gx) + qmul(dyx, gy));
               sy = clamp32(qmul(dxy, gx) + qmul(dyy, gy));
               ix = qdiv(sx, d);
               iy = qdiv(sy, d);
            end else begin
               ix = gx;
               iy = gy;
            end
            ixx = qmul(ix, x); iyy = qmul(iy, y);
            ixy = qmul(ix, y); iyx = qmul(iy, x);
            e.jac_0 = 32'(clamp32(ixx - iyy));
            e.jac_1 = 32'(ixy);
            e.jac_2 = 32'(ix);
            e.jac_3 = 32'(iyx);
            e.jac_4 = 32'(clamp32(ixx + 2 * iyy));
            e.jac_5 = 32'(iy);
            e.jac_6 = 32'(clamp32(-qmul(ixx, x) - qmul(iyy, x)));
            e.jac_7 = 32'(clamp32(-qmul(ixx, y) - qmul(iyy, y)));
         end
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected result", '0, got);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got !== e) report("field mismatch", e, got);
      endfunction

      function void report(string what, rsp_type e, rsp_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s: exp jac %h %h %h %h %h %h %h %h last %b err %b", what,
                     e.jac_0, e.jac_1, e.jac_2, e.jac_3, e.jac_4, e.jac_5,
                     e.jac_6, e.jac_7, e.last_out, e.depth_error);
            $display("   got jac %h %h %h %h %h %h %h %h last %b err %b",
                     got.jac_0, got.jac_1, got.jac_2, got.jac_3, got.jac_4,
                     got.jac_5, got.jac_6, got.jac_7, got.last_out,
                     got.depth_error);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_start = 1'b0;
   logic req_busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   jacobian_scoreboard sb = new();
   int cycles = 0;
   int samples_sent = 0;
   bit calm = 0;

   sl3_homography_pixel_jacobian #(.FRAC_BITS(FRAC)) dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check every result at the edge that ends its strobe cycle.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe) sb.check_result(rsp_data);
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Write one register through the config channel; hold until accepted.
   task automatic write_reg(csr_idx_type idx, logic [31:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_reg(idx, v);
      @(posedge clock);
   endtask

   // Drive one sample; the transfer is noted when start meets !busy.
   task automatic send_sample(req_type r);
      while (!calm && $urandom_range(99) < 14) begin
         req_start <= 1'b0;
         @(posedge clock);
      end
      req_start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_busy);
      sb.note_sample(r);
      samples_sent++;
   endtask

   // Drop start and let the pipe drain before touching registers.
   task automatic drain();
      req_start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 4) @(posedge clock);
   endtask

   // Pick a value: edges, small Q16.16 numbers, or full-range noise.
   function automatic logic [31:0] pick();
      case ($urandom_range(9))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return '0;
         3, 4: return $urandom;
         default: return 32'($signed($urandom_range(20 << 16)) - (10 << 16));
      endcase
   endfunction

   function automatic req_type rand_sample(bit zero_depth_ok);
      req_type r;
      r.tmpl_x = pick(); r.tmpl_y = pick();
      r.warped_x = pick(); r.warped_y = pick();
      r.hom_depth = pick();
      if (!zero_depth_ok && r.hom_depth == 0) r.hom_depth = 32'h0001_0000;
      r.grad_x = pick(); r.grad_y = pick();
      r.last_in = $urandom_range(1);
      return r;
   endfunction

   task automatic load_warp(logic mode, logic [31:0] a00, logic [31:0] a01,
                            logic [31:0] a10, logic [31:0] a11,
                            logic [31:0] a20, logic [31:0] a21);
      write_reg(CSR_USE_WARP, {31'b0, mode});
      write_reg(CSR_WARP_00, a00);
      write_reg(CSR_WARP_01, a01);
      write_reg(CSR_WARP_10, a10);
      write_reg(CSR_WARP_11, a11);
      write_reg(CSR_WARP_20, a20);
      write_reg(CSR_WARP_21, a21);
   endtask

   initial begin
      req_type r;
      sb.warp_on = 0;
      sb.w00 = 64'sd65536; sb.w01 = 0; sb.w10 = 0;
      sb.w11 = 64'sd65536; sb.w20 = 0; sb.w21 = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset registers in init mode, then field extremes.
      calm = 1;
      r = '0;
      r.tmpl_x = 32'h0002_0000; r.tmpl_y = 32'h0003_0000;
      r.grad_x = 32'h0001_8000; r.grad_y = 32'hffff_0000;
      send_sample(r);
      r = '1; send_sample(r);
      r = '0; r.tmpl_x = 32'h7fffffff; r.tmpl_y = 32'h80000000;
      r.grad_x = 32'h7fffffff; r.grad_y = 32'h80000000; send_sample(r);
      r.hom_depth = 0; r.last_in = 1; send_sample(r);  // depth ignored in init mode
      drain();
      // Warped mode at reset warp and a perspective warp; zero depth included.
      write_reg(CSR_USE_WARP, 32'd1);
      r = '0; r.tmpl_x = 32'h0001_0000; r.tmpl_y = 32'h0002_0000;
      r.warped_x = 32'h0004_0000; r.warped_y = 32'h0005_0000;
      r.hom_depth = 32'h0002_0000; r.grad_x = 32'h0003_0000;
      r.grad_y = 32'h0001_0000;
      send_sample(r);
      r.hom_depth = 0; send_sample(r);
      r.hom_depth = 32'h80000000; send_sample(r);
      r.hom_depth = 32'h0000_0001; send_sample(r);
      drain();
      load_warp(1, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 32'h80000000);
      r = '1; send_sample(r);
      r.hom_depth = 32'h7fffffff; send_sample(r);
      r = '0; r.tmpl_x = 32'h80000000; r.warped_x = 32'h7fffffff;
      r.warped_y = 32'h80000000; r.hom_depth = 32'hffffffff;
      r.grad_x = 32'h7fffffff; r.grad_y = 32'h7fffffff; send_sample(r);
      drain();

      // Random phases, each with its own register setting.
      for (int ph = 0; ph < 12; ph++) begin
         calm = (ph == 3);
         if (ph == 11)
            load_warp(0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0, 0);
         else if (ph % 3 == 0)
            load_warp(1, pick(), pick(), pick(), pick(), pick(), pick());
         else
            load_warp(ph % 4 != 1, 32'($signed($urandom_range(1 << 17))),
                      32'($signed($urandom_range(1 << 14)) - (1 << 13)),
                      32'($signed($urandom_range(1 << 14)) - (1 << 13)),
                      32'($signed($urandom_range(1 << 17))),
                      32'($signed($urandom_range(1 << 10)) - (1 << 9)),
                      32'($signed($urandom_range(1 << 10)) - (1 << 9)));
         for (int i = 0; i < 140; i++) send_sample(rand_sample(i % 7 == 0));
         drain();
      end

      $display("Ran %0d samples, %0d results checked, in init and warped mode", samples_sent,
               sb.checked);
      $display("over extreme and random warp settings, including zero depth.");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches,
                  sb.pending.size());
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

### files.f
rtl/sl3hj_pkg.sv
rtl/sl3hj_div.sv
rtl/sl3_homography_pixel_jacobian.sv
test/sl3_homography_pixel_jacobian_tb.sv
